/* rtl/fsts_pkg.sv */
// ----------------------------------------------------------------------------
// fsts_pkg
// shared codes, widths and controller/datapath interface types for the
// fixed-step tick scheduler
// ----------------------------------------------------------------------------
package fsts_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned REQ_W    = 4;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned RATE_W   = 10;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PERIOD_W = 10;

  localparam logic [REQ_W-1:0] REQ_RESET     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DECIDE    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_TICK_DONE = 4'd3;
  localparam logic [REQ_W-1:0] REQ_RENDER    = 4'd4;
  localparam logic [REQ_W-1:0] REQ_UNSCHED   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DRIFT     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_EXCL_BEG  = 4'd7;
  localparam logic [REQ_W-1:0] REQ_EXCL_END  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_FRACTION  = 4'd9;

  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_IDLE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RENDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNCAPPED  = 2'd3;

  localparam logic [RATE_W-1:0] RATE_RESET  = 10'd30;
  localparam logic [BYTE_W-1:0] CATCH_RESET = 8'd5;
  localparam logic [BYTE_W-1:0] GUARD_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'hFF;

  localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic capture;
    logic mul_hi;
    logic div_start;
    logic div_frac;
    logic off_store;
    logic n_prev;
    logic frac_prev;
    logic frac_diff;
    logic frac_class;
    logic frac_store;
    logic finish;
  } fsts_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             tc_zero;
    logic             div_done;
    logic             frac_need_div;
    logic             out_free;
  } fsts_stat_t;

endpackage

/* rtl/fixed_step_tick_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// fixed_step_tick_scheduler_unit
// fixed-step tick scheduler: one event per transaction, one result each
// decide and fraction queries run the deadline offsets through the divider;
//   a fraction query skips them with no ticks yet and skips its final divide
//   when none is needed
// throughput: one transaction at a time, held by the bit-serial divider that
//   produces one quotient bit per cycle for each deadline offset, and by a stalled result
// reset: asynchronous active-low, loads register defaults and clears state
// ----------------------------------------------------------------------------
module fixed_step_tick_scheduler_unit import fsts_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [TIME_W-1:0] now_ms_i,
  input  logic                     use_stored_time_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ACT_W-1:0]         action_o,
  output logic                     tick_due_o,
  output logic [FRAC_W-1:0]        fraction_q16_o,
  output logic                     error_o,
  output logic [TOTAL_W-1:0]       tick_total_o,
  output logic [TOTAL_W-1:0]       frame_total_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [RATE_W-1:0]        cfg_data_i
);

  fsts_cmd_t  cmd;
  fsts_stat_t stat;

  fsts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fsts_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .now_ms_i          (now_ms_i),
    .use_stored_time_i (use_stored_time_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .action_o          (action_o),
    .tick_due_o        (tick_due_o),
    .fraction_q16_o    (fraction_q16_o),
    .error_o           (error_o),
    .tick_total_o      (tick_total_o),
    .frame_total_o     (frame_total_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  a_due_matches_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tick_due_o == (action_o == ACT_TICK)))
    else $error("tick_due disagrees with action");

  a_error_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (action_o == ACT_IDLE) && (fraction_q16_o == '0))
    else $error("error result carries a decision or fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fraction_q16_o <= Q16_ONE)
    else $error("fraction above one");

endmodule

/* rtl/fsts_div.sv */
// ----------------------------------------------------------------------------
// fsts_div
// bit-serial restoring divider, one quotient bit per cycle, divisor up to
// ten bits
// ----------------------------------------------------------------------------
module fsts_div import fsts_pkg::*; #(
  parameter int unsigned DW = 42
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic [DW-1:0]       quotient_o
);

  localparam int unsigned CW = $clog2(DW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     sh_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [PERIOD_W-1:0] div_q;
  logic [PERIOD_W:0]   partial;
  logic                ge;
  logic [PERIOD_W-1:0] rem_next;
  logic                last;

  always_comb begin
    partial  = {rem_q, sh_q[DW-1]};
    ge       = partial >= {1'b0, div_q};
    rem_next = ge ? PERIOD_W'(partial - {1'b0, div_q}) : partial[PERIOD_W-1:0];
    last     = cnt_q == CW'(DW - 1);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= {sh_q[DW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

/* rtl/fsts_ctrl.sv */
// ----------------------------------------------------------------------------
// fsts_ctrl
// sequencing state machine: capture, deadline offsets, fraction steps and
// result write-back
// ----------------------------------------------------------------------------
module fsts_ctrl import fsts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  fsts_stat_t stat_i,
  output fsts_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_MUL_HI  = 4'd2;
  localparam logic [3:0] S_MUL_LO  = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_F_PREV  = 4'd5;
  localparam logic [3:0] S_F_DIFF  = 4'd6;
  localparam logic [3:0] S_F_CLASS = 4'd7;
  localparam logic [3:0] S_F_DIV   = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.n_prev = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        phase_d = 1'b0;
        if (stat_i.req == REQ_DECIDE ||
            (stat_i.req == REQ_FRACTION && !stat_i.tc_zero)) begin
          state_d = S_MUL_HI;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.off_store = 1'b1;
          if (stat_i.req == REQ_DECIDE) begin
            state_d = S_FINISH;
          end else if (!phase_q) begin
            phase_d = 1'b1;
            state_d = S_MUL_HI;
          end else begin
            state_d = S_F_PREV;
          end
        end
      end
      S_F_PREV: begin
        cmd_o.frac_prev = 1'b1;
        state_d = S_F_DIFF;
      end
      S_F_DIFF: begin
        cmd_o.frac_diff = 1'b1;
        state_d = S_F_CLASS;
      end
      S_F_CLASS: begin
        if (stat_i.frac_need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_frac  = 1'b1;
          state_d = S_F_DIV;
        end else begin
          cmd_o.frac_class = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_F_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.frac_store = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

/* rtl/fsts_dp.sv */
// ----------------------------------------------------------------------------
// fsts_dp
// datapath: configuration and scheduler state, deadline offset arithmetic,
// fraction computation and result register
// ----------------------------------------------------------------------------
module fsts_dp import fsts_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fsts_cmd_t                cmd_i,
  output fsts_stat_t               stat_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [TIME_W-1:0] now_ms_i,
  input  logic                     use_stored_time_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [RATE_W-1:0]        cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [ACT_W-1:0]         action_o,
  output logic                     tick_due_o,
  output logic [FRAC_W-1:0]        fraction_q16_o,
  output logic                     error_o,
  output logic [TOTAL_W-1:0]       tick_total_o,
  output logic [TOTAL_W-1:0]       frame_total_o
);

  localparam int unsigned DW = COUNT_BITS + 10;

  // configuration
  logic [RATE_W-1:0] rate_q;
  logic [BYTE_W-1:0] max_catch_q;
  logic [BYTE_W-1:0] guard_q;
  logic              uncapped_q;

  // scheduler state
  logic [TIME_W-1:0]     last_time_q, last_time_d;
  logic [TIME_W-1:0]     time_base_q, time_base_d;
  logic [TIME_W-1:0]     excl_q, excl_d;
  logic [TIME_W-1:0]     exb_q, exb_d;
  logic [COUNT_BITS-1:0] tc_q, tc_d;
  logic [COUNT_BITS-1:0] fc_q, fc_d;
  logic [BYTE_W-1:0]     cu_q, cu_d;
  logic                  known_q, known_d;
  logic                  rendered_q, rendered_d;
  logic [BYTE_W-1:0]     nest_q, nest_d;

  // per-transaction work registers
  logic [REQ_W-1:0]    req_q;
  logic [TIME_W-1:0]   time_q;
  logic [TIME_W-1:0]   span_q;
  logic [DW-1:0]       mul_q;
  logic [TIME_W-1:0]   origin_q;
  logic [TIME_W-1:0]   off_a_q;
  logic [TIME_W-1:0]   off_b_q;
  logic [TIME_W-1:0]   prev_q;
  logic [TIME_W-1:0]   d_q;
  logic [PERIOD_W-1:0] period_q;
  logic [FRAC_W-1:0]   frac_q;

  // result register
  logic              out_valid_q;
  logic [ACT_W-1:0]  action_q;
  logic              due_q;
  logic [FRAC_W-1:0] frac_out_q;
  logic              err_q;

  logic [RATE_W-1:0]     rate_eff;
  logic [COUNT_BITS-1:0] n_sel;
  logic [DW-1:0]         n_ext;
  logic [DW-1:0]         div_dividend;
  logic [PERIOD_W-1:0]   div_divisor;
  logic                  div_done;
  logic [DW-1:0]         quotient;
  logic [TIME_W-1:0]     off_val;
  logic [TIME_W-1:0]     off_diff;
  logic [31:0]           due32;
  logic                  due_c;
  logic                  d_zero;
  logic                  d_neg;
  logic                  d_below;
  logic                  p_zero;
  logic [COUNT_BITS-1:0] tc_inc;
  logic [COUNT_BITS-1:0] fc_inc;
  logic [BYTE_W-1:0]     cu_inc;

  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign n_sel    = cmd_i.n_prev ? tc_q - COUNT_BITS'(1) : tc_q;
  assign n_ext    = DW'(n_sel);

  assign div_dividend = cmd_i.div_frac ? DW'({d_q[PERIOD_W-1:0], 16'h0000})
                                       : mul_q - (n_ext << 3);
  assign div_divisor  = cmd_i.div_frac ? period_q : rate_eff;
  assign off_val      = TIME_W'(quotient);
  assign off_diff     = off_a_q - off_b_q;

  fsts_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // tick due test on the low 32 bits
  always_comb begin
    due32 = origin_q[31:0] + off_a_q[31:0];
    due_c = (nest_q == '0) && ($signed(time_q[31:0]) > $signed(due32)) &&
            (cu_q <= max_catch_q) &&
            (rendered_q || (tc_q >= COUNT_BITS'(guard_q)));
  end

  always_comb begin
    d_zero  = d_q == '0;
    d_neg   = d_q[TIME_W-1];
    p_zero  = period_q == '0;
    d_below = d_q < TIME_W'(period_q);
  end

  assign tc_inc = (tc_q == '1) ? tc_q : tc_q + COUNT_BITS'(1);
  assign fc_inc = (fc_q == '1) ? fc_q : fc_q + COUNT_BITS'(1);
  assign cu_inc = (cu_q == BYTE_MAX) ? cu_q : cu_q + BYTE_W'(1);

  always_comb begin
    last_time_d = last_time_q;
    time_base_d = time_base_q;
    excl_d      = excl_q;
    exb_d       = exb_q;
    tc_d        = tc_q;
    fc_d        = fc_q;
    cu_d        = cu_q;
    known_d     = known_q;
    rendered_d  = rendered_q;
    nest_d      = nest_q;
    if (cmd_i.finish) begin
      case (req_q)
        REQ_RESET: begin
          last_time_d = time_q;
          time_base_d = time_q;
          excl_d      = '0;
          exb_d       = '0;
          tc_d        = '0;
          fc_d        = '0;
          cu_d        = '0;
          known_d     = 1'b0;
          rendered_d  = 1'b1;
          nest_d      = '0;
        end
        REQ_UPDATE: begin
          if (!known_q) begin
            time_base_d = time_q;
            known_d     = 1'b1;
          end
          last_time_d = time_q;
        end
        REQ_TICK_DONE: begin
          tc_d       = tc_inc;
          rendered_d = 1'b0;
          cu_d       = cu_inc;
        end
        REQ_RENDER: begin
          fc_d       = fc_inc;
          rendered_d = 1'b1;
          cu_d       = '0;
        end
        REQ_UNSCHED: begin
          tc_d = tc_inc;
          fc_d = fc_inc;
        end
        REQ_DRIFT: begin
          cu_d   = '0;
          excl_d = '0;
        end
        REQ_EXCL_BEG: begin
          if (nest_q != BYTE_MAX) begin
            if (nest_q == '0) begin
              exb_d = time_q;
            end
            nest_d = nest_q + BYTE_W'(1);
          end
        end
        REQ_EXCL_END: begin
          if (nest_q != '0) begin
            nest_d = nest_q - BYTE_W'(1);
            if (nest_q == BYTE_W'(1)) begin
              excl_d      = excl_q + span_q;
              exb_d       = '0;
              last_time_d = time_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RESET;
      max_catch_q <= CATCH_RESET;
      guard_q     <= GUARD_RESET;
      uncapped_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_RATE: rate_q      <= cfg_data_i;
        CFG_MAX_CATCH: max_catch_q <= cfg_data_i[BYTE_W-1:0];
        CFG_GUARD:     guard_q     <= cfg_data_i[BYTE_W-1:0];
        CFG_UNCAPPED:  uncapped_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      time_base_q <= '0;
      excl_q      <= '0;
      exb_q       <= '0;
      tc_q        <= '0;
      fc_q        <= '0;
      cu_q        <= '0;
      known_q     <= 1'b0;
      rendered_q  <= 1'b1;
      nest_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_time_q <= last_time_d;
      time_base_q <= time_base_d;
      excl_q      <= excl_d;
      exb_q       <= exb_d;
      tc_q        <= tc_d;
      fc_q        <= fc_d;
      cu_q        <= cu_d;
      known_q     <= known_d;
      rendered_q  <= rendered_d;
      nest_q      <= nest_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      time_q <= (req_type_i == REQ_DECIDE && use_stored_time_i) ? last_time_q
                                                                  : now_ms_i;
      span_q <= now_ms_i - exb_q;
      frac_q <= Q16_ONE;
    end
    if (cmd_i.mul_hi) begin
      mul_q    <= (n_ext << 10) - (n_ext << 4);
      origin_q <= time_base_q + excl_q;
    end
    if (cmd_i.off_store) begin
      if (cmd_i.n_prev) begin
        off_b_q <= off_val;
      end else begin
        off_a_q <= off_val;
      end
    end
    if (cmd_i.frac_prev) begin
      prev_q   <= origin_q + off_b_q;
      period_q <= off_diff[PERIOD_W-1:0];
    end
    if (cmd_i.frac_diff) begin
      d_q <= time_q - prev_q;
    end
    if (cmd_i.frac_class) begin
      frac_q <= (!p_zero && (d_zero || d_neg)) ? '0 : Q16_ONE;
    end
    if (cmd_i.frac_store) begin
      frac_q <= quotient[FRAC_W-1:0];
    end
    if (cmd_i.finish) begin
      due_q      <= (req_q == REQ_DECIDE) && due_c;
      err_q      <= (req_q == REQ_EXCL_END) && (nest_q == '0);
      frac_out_q <= (req_q == REQ_FRACTION) ? frac_q : '0;
      if (req_q == REQ_DECIDE) begin
        if (due_c) begin
          action_q <= ACT_TICK;
        end else if (rendered_q && !uncapped_q) begin
          action_q <= ACT_IDLE;
        end else begin
          action_q <= ACT_RENDER;
        end
      end else begin
        action_q <= ACT_IDLE;
      end
    end
  end

  if (COUNT_BITS > TOTAL_W) begin : g_total_sat
    assign tick_total_o  = (|tc_q[COUNT_BITS-1:TOTAL_W]) ? '1 : tc_q[TOTAL_W-1:0];
    assign frame_total_o = (|fc_q[COUNT_BITS-1:TOTAL_W]) ? '1 : fc_q[TOTAL_W-1:0];
  end else begin : g_total_ext
    assign tick_total_o  = TOTAL_W'(tc_q);
    assign frame_total_o = TOTAL_W'(fc_q);
  end

  assign stat_o.req           = req_q;
  assign stat_o.tc_zero       = tc_q == '0;
  assign stat_o.div_done      = div_done;
  assign stat_o.frac_need_div = !p_zero && !d_zero && !d_neg && d_below;
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign tick_due_o     = due_q;
  assign fraction_q16_o = frac_out_q;
  assign error_o        = err_q;

endmodule

/* test/tick_sched_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_sched_checker
// watches the event and result channels and the register port of the
// fixed-step tick scheduler, keeps its own copy of the schedule state,
// predicts the result of every accepted event and compares it field by field
// ----------------------------------------------------------------------------
module tick_sched_checker import fsts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 use_stored_time_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ACT_W-1:0]     action_i,
  input  logic                 tick_due_i,
  input  logic [FRAC_W-1:0]    fraction_q16_i,
  input  logic                 error_i,
  input  logic [TOTAL_W-1:0]   tick_total_i,
  input  logic [TOTAL_W-1:0]   frame_total_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          result_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               tick_due;
    logic [FRAC_W-1:0]  fraction;
    logic               err;
    logic [TOTAL_W-1:0] ticks;
    logic [TOTAL_W-1:0] frames;
  } sched_result_t;

  logic [RATE_W-1:0]  rate_hz;
  logic [BYTE_W-1:0]  catch_cap;
  logic [BYTE_W-1:0]  guard_ticks;
  logic               uncapped;

  logic [TIME_W-1:0]  stored_ms;
  logic [TIME_W-1:0]  base_ms;
  logic [TIME_W-1:0]  excluded_ms;
  logic [TIME_W-1:0]  excl_start_ms;
  logic [TOTAL_W-1:0] ticks_done;
  logic [TOTAL_W-1:0] frames_done;
  logic [BYTE_W-1:0]  catch_up;
  logic [BYTE_W-1:0]  excl_depth;
  logic               base_set;
  logic               rendered;

  sched_result_t      expected_results[$];
  int unsigned        failures;
  int unsigned        results;

  // floor(n * 1000 / rate) without overflow, rate of zero counts as one
  function automatic logic [TIME_W-1:0] schedule_offset(input logic [TIME_W-1:0] n);
    logic [TIME_W-1:0] r;
    r = TIME_W'(rate_hz);
    if (r == '0) r = TIME_W'(1);
    return (n / r) * 64'd1000 + ((n % r) * 64'd1000) / r;
  endfunction

  function automatic logic [TIME_W-1:0] deadline_ms(input logic [TIME_W-1:0] n);
    return base_ms + excluded_ms + schedule_offset(n);
  endfunction

  function automatic logic tick_ready(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] due;
    due = deadline_ms(TIME_W'(ticks_done));
    if (excl_depth != '0) return 1'b0;
    if ($signed(t[31:0]) <= $signed(due[31:0])) return 1'b0;
    if (catch_up > catch_cap) return 1'b0;
    return rendered || (ticks_done >= guard_ticks);
  endfunction

  function automatic logic [FRAC_W-1:0] fraction_at(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] n;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] d;
    if (ticks_done == '0) return Q16_ONE;
    n = TIME_W'(ticks_done);
    period = schedule_offset(n) - schedule_offset(n - 1);
    if (period == '0 || period[TIME_W-1]) return Q16_ONE;
    prev = deadline_ms(n - 1);
    d = t - prev;
    if (d == '0 || d[TIME_W-1]) return '0;
    if (d >= period) return Q16_ONE;
    return FRAC_W'((d * 64'd65536) / period);
  endfunction

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic clear_state(input logic [TIME_W-1:0] t);
    stored_ms     = t;
    base_ms       = t;
    excluded_ms   = '0;
    excl_start_ms = '0;
    ticks_done    = '0;
    frames_done   = '0;
    catch_up      = '0;
    excl_depth    = '0;
    base_set      = 1'b0;
    rendered      = 1'b1;
  endtask

  task automatic predict_event(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                               input logic stored, output sched_result_t r);
    r = '0;
    r.action = ACT_IDLE;
    case (req)
      REQ_RESET: clear_state(t);
      REQ_UPDATE: begin
        if (!base_set) begin
          base_ms  = t;
          base_set = 1'b1;
        end
        stored_ms = t;
      end
      REQ_DECIDE: begin
        if (tick_ready(stored ? stored_ms : t)) begin
          r.tick_due = 1'b1;
          r.action   = ACT_TICK;
        end else begin
          r.action = (rendered && !uncapped) ? ACT_IDLE : ACT_RENDER;
        end
      end
      REQ_TICK_DONE: begin
        ticks_done = bump(ticks_done);
        rendered   = 1'b0;
        if (catch_up != BYTE_MAX) catch_up = catch_up + 1'b1;
      end
      REQ_RENDER: begin
        frames_done = bump(frames_done);
        rendered    = 1'b1;
        catch_up    = '0;
      end
      REQ_UNSCHED: begin
        ticks_done  = bump(ticks_done);
        frames_done = bump(frames_done);
      end
      REQ_DRIFT: begin
        catch_up    = '0;
        excluded_ms = '0;
      end
      REQ_EXCL_BEG: begin
        if (excl_depth != BYTE_MAX) begin
          if (excl_depth == '0) excl_start_ms = t;
          excl_depth = excl_depth + 1'b1;
        end
      end
      REQ_EXCL_END: begin
        if (excl_depth == '0) begin
          r.err = 1'b1;
        end else begin
          excl_depth = excl_depth - 1'b1;
          if (excl_depth == '0) begin
            excluded_ms   = excluded_ms + (t - excl_start_ms);
            excl_start_ms = '0;
            stored_ms     = t;
          end
        end
      end
      REQ_FRACTION: r.fraction = fraction_at(t);
      default: ;
    endcase
    r.ticks  = ticks_done;
    r.frames = frames_done;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t r;
    if (!rst_ni) begin
      rate_hz     = RATE_RESET;
      catch_cap   = CATCH_RESET;
      guard_ticks = GUARD_RESET;
      uncapped    = 1'b0;
      clear_state('0);
      expected_results.delete();
      failures = 0;
      results  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TICK_RATE: rate_hz     = cfg_data_i;
          CFG_MAX_CATCH: catch_cap   = cfg_data_i[BYTE_W-1:0];
          CFG_GUARD:     guard_ticks = cfg_data_i[BYTE_W-1:0];
          CFG_UNCAPPED:  uncapped    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_event(req_type_i, now_ms_i, use_stored_time_i, r);
        expected_results.push_back(r);
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_results.size() == 0) begin
          $error("result transaction with no event outstanding");
          failures++;
        end else begin
          r = expected_results.pop_front();
          check_field("action", TIME_W'(r.action), TIME_W'(action_i));
          check_field("tick_due", TIME_W'(r.tick_due), TIME_W'(tick_due_i));
          check_field("fraction_q16", TIME_W'(r.fraction), TIME_W'(fraction_q16_i));
          check_field("error", TIME_W'(r.err), TIME_W'(error_i));
          check_field("tick_total", TIME_W'(r.ticks), TIME_W'(tick_total_i));
          check_field("frame_total", TIME_W'(r.frames), TIME_W'(frame_total_i));
        end
      end
    end
    fail_count_o   <= failures;
    result_count_o <= results;
    pending_o      <= expected_results.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the fixed-step tick scheduler with directed events, long counter and
// nesting bursts and random game-loop frames over several register settings
// and handshake idling patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb;
  import fsts_pkg::*;

  localparam int unsigned QUIET_LIMIT      = 3000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned DRAIN_CYCLES     = 150;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned FRAMES_PER_PHASE = 12;
  localparam int unsigned BURST_LEN        = 256;
  localparam logic [REQ_W-1:0] REQ_UNUSED_TOP = '1;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i        = '0;
  logic [TIME_W-1:0]    now_ms_i          = '0;
  logic                 use_stored_time_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic [ACT_W-1:0]     action_o;
  logic                 tick_due_o;
  logic [FRAC_W-1:0]    fraction_q16_o;
  logic                 error_o;
  logic [TOTAL_W-1:0]   tick_total_o;
  logic [TOTAL_W-1:0]   frame_total_o;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = '0;
  logic [RATE_W-1:0]    cfg_data_i        = '0;

  int unsigned          fail_count;
  int unsigned          result_count;
  int unsigned          pending;
  int unsigned          sent_count        = 0;
  int unsigned          quiet_cycles      = 0;
  int unsigned          send_idle_pct     = 0;
  int unsigned          recv_stall_pct    = 0;
  logic [TIME_W-1:0]    clock_ms          = '0;

  fixed_step_tick_scheduler_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .now_ms_i          (now_ms_i),
    .use_stored_time_i (use_stored_time_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .action_o          (action_o),
    .tick_due_o        (tick_due_o),
    .fraction_q16_o    (fraction_q16_o),
    .error_o           (error_o),
    .tick_total_o      (tick_total_o),
    .frame_total_o     (frame_total_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  tick_sched_checker sched_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .req_type_i        (req_type_i),
    .now_ms_i          (now_ms_i),
    .use_stored_time_i (use_stored_time_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .action_i          (action_o),
    .tick_due_i        (tick_due_o),
    .fraction_q16_i    (fraction_q16_o),
    .error_i           (error_o),
    .tick_total_i      (tick_total_o),
    .frame_total_i     (frame_total_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .result_count_o    (result_count),
    .pending_o         (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                            input logic stored);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    req_type_i        <= req;
    now_ms_i          <= t;
    use_stored_time_i <= stored;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  // upper data bits beyond a register's width are random and must be ignored
  task automatic write_regs(input logic [RATE_W-1:0] rate, input logic [BYTE_W-1:0] cap,
                            input logic [BYTE_W-1:0] guard, input logic unc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TICK_RATE;
    cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_CATCH;
    cfg_data_i <= RATE_W'({$urandom, cap});
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GUARD;
    cfg_data_i <= RATE_W'({$urandom, guard});
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNCAPPED;
    cfg_data_i <= RATE_W'({$urandom, unc});
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // one game-loop frame with random extras, noise and broken sequences
  task automatic run_frame();
    int unsigned roll;
    clock_ms += $urandom_range(45);
    send_event(REQ_UPDATE, clock_ms, 1'($urandom_range(1)));
    send_event(REQ_DECIDE, clock_ms + $urandom_range(3), 1'($urandom_range(1)));
    roll = $urandom_range(99);
    if (roll < 55) send_event(REQ_TICK_DONE, clock_ms, 1'b0);
    if (roll < 15) send_event(REQ_TICK_DONE, clock_ms, 1'b0);
    if ($urandom_range(99) < 60) send_event(REQ_RENDER, clock_ms, 1'b0);
    if ($urandom_range(99) < 25) begin
      send_event(REQ_FRACTION, clock_ms + $urandom_range(40) - 5, 1'($urandom_range(1)));
    end
    roll = $urandom_range(99);
    if (roll < 6) begin
      send_event(REQ_EXCL_BEG, clock_ms, 1'b0);
      if (roll < 2) send_event(REQ_EXCL_BEG, clock_ms + 1, 1'b0);
      clock_ms += $urandom_range(150);
      send_event(REQ_DECIDE, clock_ms, 1'b0);
      if (roll < 2) send_event(REQ_EXCL_END, clock_ms, 1'b0);
      send_event(REQ_EXCL_END, clock_ms, 1'b0);
    end else if (roll < 9) begin
      send_event(REQ_DRIFT, clock_ms, 1'b0);
    end else if (roll < 12) begin
      send_event(REQ_UNSCHED, clock_ms, 1'b0);
    end else if (roll < 14) begin
      send_event(REQ_RESET, clock_ms, 1'b0);
    end else if (roll < 17) begin
      send_event(REQ_EXCL_END, clock_ms, 1'b0);
    end else if (roll < 23) begin
      send_event(REQ_W'($urandom_range(REQ_UNUSED_TOP)), {$urandom, $urandom},
                 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(REQ_FRACTION, 64'd5, 1'b0);
    send_event(REQ_EXCL_END, 64'd7, 1'b0);
    send_event(REQ_UPDATE, 64'd1000, 1'b0);
    send_event(REQ_UPDATE, 64'd1010, 1'b1);
    send_event(REQ_DECIDE, 64'd0, 1'b1);
    send_event(REQ_TICK_DONE, 64'd0, 1'b0);
    send_event(REQ_DECIDE, 64'd1020, 1'b0);
    send_event(REQ_RENDER, 64'd0, 1'b0);
    send_event(REQ_FRACTION, 64'd1020, 1'b0);
    send_event(REQ_FRACTION, 64'd999, 1'b0);
    send_event(REQ_FRACTION, 64'd5000, 1'b0);
    send_event(REQ_EXCL_BEG, 64'd1040, 1'b0);
    send_event(REQ_EXCL_BEG, 64'd1050, 1'b0);
    send_event(REQ_DECIDE, 64'd1060, 1'b0);
    send_event(REQ_EXCL_END, 64'd1070, 1'b0);
    send_event(REQ_EXCL_END, 64'd1100, 1'b0);
    send_event(REQ_DECIDE, 64'd0, 1'b1);
    send_event(REQ_DRIFT, 64'd0, 1'b0);
    send_event(REQ_UNSCHED, 64'd0, 1'b0);
    send_event(REQ_UNUSED_TOP, '1, 1'b1);
    send_event(REQ_DECIDE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_DECIDE, 64'h8000_0000_0000_0000, 1'b0);
    send_event(REQ_RESET, '1, 1'b0);
    send_event(REQ_FRACTION, '0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      in_valid_i <= 1'b0;
      while (result_count != sent_count) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (p)
        0: write_regs(RATE_RESET, CATCH_RESET, GUARD_RESET, 1'b0);
        1: write_regs(10'd1, 8'd0, 8'd0, 1'b0);
        2: write_regs(10'd1000, BYTE_MAX, BYTE_MAX, 1'b1);
        3: write_regs(10'd0, 8'd3, 8'd1, 1'b1);
        4: write_regs('1, BYTE_MAX, 8'd0, 1'b0);
        default: write_regs(RATE_W'($urandom_range(1023)), BYTE_W'($urandom_range(255)),
                            BYTE_W'($urandom_range(8)), 1'($urandom_range(1)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // random bases and bases near the 32-bit sign flip and the 64-bit wrap
      case (p % 3)
        0: clock_ms = {$urandom, $urandom};
        1: clock_ms = 64'h0000_0000_7FFF_FF00 + $urandom_range(255);
        default: clock_ms = 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(255);
      endcase
      send_event(REQ_RESET, clock_ms, 1'b0);
      for (int f = 0; f < FRAMES_PER_PHASE; f++) run_frame();
      if (p == 0) begin
        // saturate the catch-up count, then fill the exclusion nesting
        repeat (BURST_LEN + 1) send_event(REQ_TICK_DONE, clock_ms, 1'b0);
        send_event(REQ_DECIDE, clock_ms + 64'd100000, 1'b0);
        send_event(REQ_FRACTION, clock_ms + 64'd20, 1'b0);
        send_event(REQ_RENDER, clock_ms, 1'b0);
        send_event(REQ_DECIDE, clock_ms + 64'd100000, 1'b0);
        repeat (BURST_LEN) send_event(REQ_EXCL_BEG, clock_ms, 1'b0);
        send_event(REQ_DECIDE, clock_ms + 64'd100000, 1'b0);
        send_event(REQ_EXCL_END, clock_ms + 64'd5, 1'b0);
        send_event(REQ_RESET, clock_ms, 1'b0);
        send_event(REQ_UPDATE, clock_ms, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    while (result_count != sent_count) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
